// ===== design/tssr_pkg.sv =====
// Package for the tile/sprite scanline renderer: command codes, register
// indexes, layer codes, sizes. Used by top level and testbench; no dependencies.
`default_nettype none
package tssr_pkg;
  localparam int VMEM_DEPTH = 8192;
  localparam int SPR_BYTES = 160;
  localparam int MAX_SPRITES = 40;
  localparam int DEF_LINE_WIDTH = 160;

  typedef enum logic [1:0] {
    CMD_VMEM_WR = 2'd0,
    CMD_SPR_WR  = 2'd1,
    CMD_RENDER  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_LCDC = 3'd0,
    REG_SCY  = 3'd1,
    REG_SCX  = 3'd2,
    REG_WY   = 3'd3,
    REG_WX   = 3'd4,
    REG_PAL  = 3'd5
  } reg_idx_t;

  localparam logic [1:0] SRC_BLANK = 2'd0;
  localparam logic [1:0] SRC_BG    = 2'd1;
  localparam logic [1:0] SRC_WIN   = 2'd2;
  localparam logic [1:0] SRC_SPR   = 2'd3;

  function automatic logic [1:0] pal_shade(input logic [7:0] pal, input logic [1:0] c);
    logic [1:0] s;
    case (c)
      2'd0:    s = pal[1:0];
      2'd1:    s = pal[3:2];
      2'd2:    s = pal[5:4];
      default: s = pal[7:6];
    endcase
    return s;
  endfunction
endpackage
`default_nettype wire

// ===== design/tile_sprite_scanline_pixel_renderer.sv =====
// Top level of the tile/sprite pixel renderer: video memory, sprite table,
// registers and the render sequencer. Depends on tssr_pkg.
`default_nettype none
// A write item passes through ST_WRITE, where its store is written. A render item
// is a walk over the two memories, one synchronous read a cycle: three video
// memory reads for the background or window tile (map entry, low and high plane
// bytes), then four sprite table reads per sprite entry and two video memory reads
// for each sprite that covers the pixel, stopping at the first opaque sprite. The
// block is busy for the whole walk and takes no new item until it ends. The result
// strobe comes in the cycle after the walk ends; it cannot be stalled.
// Memories hold no reset value and need no clearing pass.
module tile_sprite_scanline_pixel_renderer #(
  parameter int SPRITE_COUNT = tssr_pkg::MAX_SPRITES,
  parameter int LINE_WIDTH   = tssr_pkg::DEF_LINE_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [12:0] in_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic [7:0]  in_line,
  input  wire logic [7:0]  in_column,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic             out_strobe,
  output logic [1:0]       out_shade,
  output logic [1:0]       out_layer_source
);
  import tssr_pkg::*;

  localparam int SW = $clog2(MAX_SPRITES + 1);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_WRITE = 10'b0000000010,
    ST_MAP   = 10'b0000000100,
    ST_TLO   = 10'b0000001000,
    ST_THI   = 10'b0000010000,
    ST_SY    = 10'b0000100000,
    ST_SX    = 10'b0001000000,
    ST_STILE = 10'b0010000000,
    ST_SATTR = 10'b0100000000,
    ST_SLO   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0] vmem [VMEM_DEPTH];
  logic [7:0] stab [SPR_BYTES];
  logic [7:0] vq_r, sq_r;
  logic        v_we, s_we;
  logic [12:0] v_addr;
  logic [7:0]  s_addr;
  logic [7:0]  wdata_r;

  logic [7:0] lcdc_r, scy_r, scx_r, wy_r, wx_r, pal_r;

  logic [7:0] line_r, col_r, tx_r, ty_r;
  logic       win_r;
  logic [7:0] lo_r, sy_r, sx_r, stile_r, sattr_r;
  logic [1:0] bgcol_r, shade_r, src_r;
  logic [SW-1:0] idx_r;
  logic [12:0] waddr_r;
  logic [12:0] taddr_r;
  logic [1:0]  cmd_r;
  logic        strobe_r;

  assign busy = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_strobe = strobe_r;
  assign out_shade = shade_r;
  assign out_layer_source = src_r;

  wire accept = start && !busy;

  // Window geometry at accept time.
  wire [7:0] win_start = (wx_r >= 8'd7) ? wx_r - 8'd7 : 8'd0;
  wire win_hit = lcdc_r[5] && (in_line >= wy_r) && (wx_r <= 8'd166) &&
                 (in_column >= win_start);
  wire [7:0] tx_nxt = win_hit ? in_column + 8'd7 - wx_r : scx_r + in_column;
  wire [7:0] ty_nxt = win_hit ? in_line - wy_r : scy_r + in_line;

  // Sprite decode from the sprite byte fields.
  wire [8:0] l16 = {1'b0, line_r} + 9'd16;
  wire [8:0] height = lcdc_r[2] ? 9'd16 : 9'd8;
  wire [8:0] c8 = {1'b0, col_r} + 9'd8;
  wire [8:0] sxe = {1'b0, sx_r};
  wire [8:0] sye = {1'b0, sy_r};
  wire spr_hit = (l16 >= sye) && (l16 < sye + height) && (sx_r != 8'd0) &&
                 (sx_r < 8'd168) && (c8 >= sxe) && (c8 < sxe + 9'd8);
  wire [8:0] rowd = l16 - sye;
  wire [3:0] row0 = rowd[3:0];
  // The attribute byte is still on the read port in ST_SATTR and registered after.
  wire sflip_y = (state_r == ST_SATTR) ? sq_r[6] : sattr_r[6];
  wire [3:0] srow = sflip_y ? (height[3:0] - 4'd1 - row0) : row0;
  wire [3:0] srow_m = lcdc_r[2] ? srow : {1'b0, srow[2:0]};
  wire [7:0] stile_m = lcdc_r[2] ? {stile_r[7:1], 1'b0} : stile_r;
  wire [8:0] pxd = c8 - sxe;
  wire [2:0] spx = sattr_r[5] ? 3'd7 - pxd[2:0] : pxd[2:0];

  // Background tile address from the map entry.
  wire [7:0] tnum = lcdc_r[4] ? vq_r : {~vq_r[7], vq_r[6:0]};
  wire [12:0] tbase = lcdc_r[4] ? 13'h0000 : 13'h0800;
  wire [12:0] trow = tbase + {1'b0, tnum, 4'b0} + {9'd0, ty_r[2:0], 1'b0};
  wire [2:0] bsh = 3'd7 - tx_r[2:0];
  wire [2:0] ssh = 3'd7 - spx;

  wire [SW-1:0] idx_inc = idx_r + SW'(1);
  wire last_spr = (idx_inc == SW'(SPRITE_COUNT));
  wire [7:0] sbase = {idx_r[5:0], 2'b00};

  always_comb begin
    state_nxt = state_r;
    v_we = 1'b0; s_we = 1'b0;
    v_addr = 13'd0; s_addr = sbase;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_RENDER && {1'b0, in_column} < 9'(LINE_WIDTH) &&
              lcdc_r[7]) begin
            if (win_hit || lcdc_r[0]) begin
              v_addr = {2'b11, win_hit ? lcdc_r[6] : lcdc_r[3], ty_nxt[7:3], tx_nxt[7:3]};
              state_nxt = ST_MAP;
            end else if (lcdc_r[1]) begin
              s_addr = 8'd0;
              state_nxt = ST_SY;
            end else state_nxt = ST_WRITE;
          end else state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: state_nxt = ST_IDLE;
      ST_MAP: begin v_addr = trow; state_nxt = ST_TLO; end
      ST_TLO: begin v_addr = taddr_r | 13'd1; state_nxt = ST_THI; end
      ST_THI: begin
        if (lcdc_r[1]) begin s_addr = 8'd0; state_nxt = ST_SY; end
        else state_nxt = ST_IDLE;
      end
      ST_SY: begin s_addr = sbase | 8'd1; state_nxt = ST_SX; end
      ST_SX: begin s_addr = sbase | 8'd2; state_nxt = ST_STILE; end
      ST_STILE: begin s_addr = sbase | 8'd3; state_nxt = ST_SATTR; end
      ST_SATTR: begin
        // sq_r holds the attribute byte.
        if (spr_hit) begin
          v_addr = {1'b0, stile_m, 4'b0} + {8'd0, srow_m, 1'b0};
          state_nxt = ST_SLO;
        end else if (last_spr) state_nxt = ST_IDLE;
        else begin s_addr = {idx_inc[5:0], 2'b00}; state_nxt = ST_SY; end
      end
      ST_SLO: begin
        v_addr = {1'b0, stile_m, 4'b0} + {8'd0, srow_m, 1'b1};
        // Fetch the next entry's Y byte in case this candidate is transparent.
        s_addr = {idx_inc[5:0], 2'b00};
        state_nxt = ST_IDLE; // resolved in the register block below
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_WRITE) begin
      v_we = (cmd_r == CMD_VMEM_WR);
      s_we = (cmd_r == CMD_SPR_WR) && (waddr_r < 13'(SPR_BYTES));
      v_addr = waddr_r;
      s_addr = waddr_r[7:0];
    end
  end

  // Sprite row data: the high byte is on vq_r in ST_SLO once slo2_r is set.
  // A small helper state lives in slo2_r.
  logic slo2_r;

  always_ff @(posedge clk) begin
    if (v_we) vmem[v_addr] <= wdata_r;
    vq_r <= vmem[v_addr];
  end

  always_ff @(posedge clk) begin
    if (s_we) stab[s_addr] <= wdata_r;
    sq_r <= stab[s_addr];
  end

  wire [1:0] bc = {vq_r[bsh], lo_r[bsh]};
  wire [1:0] sc = {vq_r[ssh], lo_r[ssh]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      strobe_r <= 1'b0;
      slo2_r <= 1'b0;
      lcdc_r <= 8'd0; scy_r <= 8'd0; scx_r <= 8'd0;
      wy_r <= 8'd0; wx_r <= 8'd0; pal_r <= 8'd0;
      idx_r <= '0;
    end else begin
      state_r <= (state_r == ST_SLO) ? ST_SLO : state_nxt;
      strobe_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LCDC: lcdc_r <= cfg_data;
          REG_SCY:  scy_r <= cfg_data;
          REG_SCX:  scx_r <= cfg_data;
          REG_WY:   wy_r <= cfg_data;
          REG_WX:   wx_r <= cfg_data;
          REG_PAL:  pal_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        idx_r <= '0;
        if (in_command == CMD_RENDER && {1'b0, in_column} < 9'(LINE_WIDTH)) begin
          strobe_r <= !lcdc_r[7] || (!win_hit && !lcdc_r[0] && !lcdc_r[1]);
        end
      end
      if (state_r == ST_THI && !lcdc_r[1]) strobe_r <= 1'b1;
      if (state_r == ST_SATTR && !spr_hit && last_spr) strobe_r <= 1'b1;
      if (state_r == ST_SATTR && !spr_hit && !last_spr) idx_r <= idx_inc;
      if (state_r == ST_SLO) begin
        slo2_r <= !slo2_r;
        if (slo2_r) begin
          if (sc != 2'd0 || last_spr) begin
            state_r <= ST_IDLE;
            strobe_r <= 1'b1;
          end else begin
            idx_r <= idx_inc;
            state_r <= ST_SY;
          end
        end
      end
    end
  end

  // Item fields and the datapath registers of the walk.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command; waddr_r <= in_address; wdata_r <= in_write_data;
      line_r <= in_line; col_r <= in_column;
      tx_r <= tx_nxt; ty_r <= ty_nxt;
      win_r <= win_hit;
      bgcol_r <= 2'd0; shade_r <= 2'd0; src_r <= SRC_BLANK;
    end
    case (state_r)
      ST_MAP: taddr_r <= trow;
      ST_TLO: lo_r <= vq_r;
      ST_THI: begin
        bgcol_r <= bc;
        shade_r <= pal_shade(pal_r, bc);
        src_r <= win_r ? SRC_WIN : SRC_BG;
      end
      ST_SY: sy_r <= sq_r;
      ST_SX: sx_r <= sq_r;
      ST_STILE: stile_r <= sq_r;
      ST_SATTR: sattr_r <= sq_r;
      ST_SLO: begin
        if (!slo2_r) lo_r <= vq_r;
        else if (sc != 2'd0 && !(sattr_r[7] && bgcol_r != 2'd0)) begin
          shade_r <= pal_shade(pal_r, sc);
          src_r <= SRC_SPR;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> !(state_r == ST_SLO))
    else $error("result strobe while sprite row pending");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r < SW'(SPRITE_COUNT))
    else $error("sprite index past table");
  a_write_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE |=> state_r == ST_IDLE)
    else $error("write did not finish");
  a_no_spr_off: assert property (@(posedge clk) disable iff (!rst_n)
    (src_r == SRC_SPR && $changed(src_r)) |-> lcdc_r[1])
    else $error("sprite source with sprites off");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/tile_sprite_scanline_pixel_renderer_tb.sv =====
// Self-checking testbench for the tile/sprite pixel renderer: memory loads,
// register phases and random items, whose pixels are checked against a local predictor.
// Depends on tssr_pkg and the tile_sprite_scanline_pixel_renderer top level.
`timescale 1ns / 1ps
module tile_sprite_scanline_pixel_renderer_tb;
  import tssr_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [1:0] shade;
    logic [1:0] source;
  } pixel_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [12:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  ln;
    logic [7:0]  col;
    bit          typed;
    pixel_t      typed_pix;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_command = CMD_VMEM_WR;
  logic [12:0] in_address = '0;
  logic [7:0] in_write_data = '0;
  logic [7:0] in_line = '0;
  logic [7:0] in_column = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_LCDC;
  logic [7:0] cfg_data = '0;
  logic out_strobe;
  logic [1:0] out_shade;
  logic [1:0] out_layer_source;

  tile_sprite_scanline_pixel_renderer DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_address(in_address), .in_write_data(in_write_data),
    .in_line(in_line), .in_column(in_column),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_strobe(out_strobe), .out_shade(out_shade), .out_layer_source(out_layer_source)
  );

  always #4 clk = ~clk;

  // Local copy of the block's stores and registers.
  logic [7:0] vmem_copy [VMEM_DEPTH];
  logic [7:0] oam_copy [SPR_BYTES];
  logic [7:0] lcdc_r, scy_r, scx_r, wy_r, wx_r, pal_r;

  pixel_t pending_pixels[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic int vram_byte(input int bus_addr);
    return vmem_copy[(bus_addr - 32'h8000) & (VMEM_DEPTH - 1)];
  endfunction

  function automatic int plane_colour(input int bus_addr, input int px);
    int lo, hi, sh;
    lo = vram_byte(bus_addr);
    hi = vram_byte(bus_addr + 1);
    sh = 7 - (px & 7);
    return (((hi >> sh) & 1) << 1) | ((lo >> sh) & 1);
  endfunction

  function automatic int tile_map_colour(input int map_base, input int x, input int y);
    int entry, tile, data_base;
    entry = vram_byte(map_base + ((y >> 3) & 31) * 32 + ((x >> 3) & 31));
    // Tile data at 0x8800 uses signed numbering, which is an xor of the top bit.
    data_base = lcdc_r[4] ? 32'h8000 : 32'h8800;
    tile = lcdc_r[4] ? entry : (entry ^ 8'h80);
    return plane_colour(data_base + tile * 16 + (y & 7) * 2, x);
  endfunction

  function automatic logic [1:0] palette_shade(input int colour);
    return pal_r[(colour & 3) * 2 +: 2];
  endfunction

  function automatic bit predict_pixel(input int ln, input int col, output pixel_t pix);
    int bgc, win_start, height, tmask, l16, sy, sx, tile, attr, row, px, c;
    bit win_on;
    pix.shade = 2'd0;
    pix.source = SRC_BLANK;
    bgc = 0;
    if (col >= DEF_LINE_WIDTH) return 1'b0;
    if (lcdc_r[7]) begin
      win_on = lcdc_r[5] && ln >= wy_r && wx_r <= 166;
      win_start = (wx_r >= 7) ? wx_r - 7 : 0;
      if (win_on && col >= win_start) begin
        bgc = tile_map_colour(lcdc_r[6] ? 32'h9C00 : 32'h9800,
                              (col + 7 - wx_r) & 255, (ln - wy_r) & 255);
        pix.shade = palette_shade(bgc);
        pix.source = SRC_WIN;
      end else if (lcdc_r[0]) begin
        bgc = tile_map_colour(lcdc_r[3] ? 32'h9C00 : 32'h9800,
                              (scx_r + col) & 255, (scy_r + ln) & 255);
        pix.shade = palette_shade(bgc);
        pix.source = SRC_BG;
      end
      if (lcdc_r[1]) begin
        height = lcdc_r[2] ? 16 : 8;
        tmask = lcdc_r[2] ? 8'hFE : 8'hFF;
        l16 = ln + 16;
        for (int i = 0; i < MAX_SPRITES; i++) begin
          sy = oam_copy[i * 4];
          sx = oam_copy[i * 4 + 1];
          tile = oam_copy[i * 4 + 2] & tmask;
          attr = oam_copy[i * 4 + 3];
          if (!(l16 >= sy && l16 < sy + height && sx != 0 && sx < 168)) continue;
          if (col + 8 < sx || col + 8 >= sx + 8) continue;
          px = col + 8 - sx;
          row = l16 - sy;
          if (attr[6]) row = height - 1 - row;
          if (attr[5]) px = 7 - px;
          c = plane_colour(32'h8000 + tile * 16 + row * 2, px);
          if (c == 0) continue;
          // A behind-background sprite still wins the pixel but shows nothing.
          if (!(attr[7] && bgc != 0)) begin
            pix.shade = palette_shade(c);
            pix.source = SRC_SPR;
          end
          break;
        end
      end
    end
    return 1'b1;
  endfunction

  // Leaves start high on return so that the next item can follow back to back.
  task automatic send_item(input stim_row_t r);
    pixel_t pix;
    start <= 1'b1;
    in_command <= r.cmd;
    in_address <= r.addr;
    in_write_data <= r.wdata;
    in_line <= r.ln;
    in_column <= r.col;
    do @(posedge clk); while (busy);
    case (r.cmd)
      CMD_VMEM_WR: vmem_copy[r.addr] = r.wdata;
      CMD_SPR_WR: if (r.addr < SPR_BYTES) oam_copy[r.addr] = r.wdata;
      CMD_RENDER: if (predict_pixel(r.ln, r.col, pix))
        pending_pixels.push_back(r.typed ? r.typed_pix : pix);
      default: ;
    endcase
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LCDC: lcdc_r = val;
      REG_SCY:  scy_r = val;
      REG_SCX:  scx_r = val;
      REG_WY:   wy_r = val;
      REG_WX:   wx_r = val;
      default:  pal_r = val;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] lc, sy, sx, wy, wx, pal);
    write_reg(REG_LCDC, lc);
    write_reg(REG_SCY, sy);
    write_reg(REG_SCX, sx);
    write_reg(REG_WY, wy);
    write_reg(REG_WX, wx);
    write_reg(REG_PAL, pal);
  endtask

  function automatic logic [7:0] sprite_byte(input int addr);
    // Keep Y and X mostly in the visible band so sprites actually land.
    if (addr % 4 < 2) return 8'($urandom_range(0, 175));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic stim_row_t random_item();
    stim_row_t r;
    int pick;
    r.typed = 1'b0;
    r.typed_pix = '0;
    r.wdata = 8'($urandom_range(0, 255));
    r.addr = 13'($urandom_range(0, 8191));
    r.ln = 8'($urandom_range(0, 143));
    r.col = 8'($urandom_range(0, 159));
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      r.cmd = CMD_RENDER;
      if ($urandom_range(0, 9) == 0) begin
        r.ln = 8'($urandom_range(0, 255));
        r.col = 8'($urandom_range(0, 255));
      end
    end else if (pick < 85) begin
      r.cmd = CMD_VMEM_WR;
    end else if (pick < 96) begin
      r.cmd = CMD_SPR_WR;
      if ($urandom_range(0, 4) != 0) r.addr = 13'($urandom_range(0, SPR_BYTES - 1));
      r.wdata = sprite_byte(r.addr);
    end else begin
      r.cmd = CMD_UNUSED;
    end
    return r;
  endfunction

  function automatic stim_row_t mk(input logic [1:0] cmd, input int addr, input int wd,
                                   input int ln, input int col, input bit typed);
    stim_row_t r;
    r.cmd = cmd;
    r.addr = 13'(addr);
    r.wdata = 8'(wd);
    r.ln = 8'(ln);
    r.col = 8'(col);
    r.typed = typed;
    r.typed_pix.shade = 2'd0;
    r.typed_pix.source = SRC_BLANK;
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_strobe) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel shade=%0d source=%0d", $time, out_shade,
                 out_layer_source);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_shade !== want.shade) begin
          $display("%0t: shade expected %0d got %0d", $time, want.shade, out_shade);
          errors++;
        end
        if (out_layer_source !== want.source) begin
          $display("%0t: layer_source expected %0d got %0d", $time, want.source,
                   out_layer_source);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || (cfg_valid && cfg_ready) || out_strobe || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  stim_row_t directed [$];

  initial begin
    stim_row_t r;
    int burst, phase;
    lcdc_r = 0; scy_r = 0; scx_r = 0; wy_r = 0; wx_r = 0; pal_r = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load every store entry so that no render ever reads an unwritten byte.
    for (int a = 0; a < VMEM_DEPTH; a++)
      send_item(mk(CMD_VMEM_WR, a, $urandom_range(0, 255), 0, 0, 1'b0));
    for (int a = 0; a < SPR_BYTES; a++)
      send_item(mk(CMD_SPR_WR, a, sprite_byte(a), 0, 0, 1'b0));

    // Registers are still at reset, so the LCD is off and every pixel is blank.
    directed.push_back(mk(CMD_RENDER, 0, 0, 0, 0, 1'b1));
    directed.push_back(mk(CMD_RENDER, 0, 255, 143, 159, 1'b1));
    directed.push_back(mk(CMD_RENDER, 8191, 0, 255, 0, 1'b1));
    directed.push_back(mk(CMD_RENDER, 0, 0, 0, 160, 1'b1));
    directed.push_back(mk(CMD_RENDER, 0, 0, 0, 255, 1'b1));
    directed.push_back(mk(CMD_VMEM_WR, 0, 255, 0, 0, 1'b0));
    directed.push_back(mk(CMD_VMEM_WR, 8191, 0, 0, 0, 1'b0));
    directed.push_back(mk(CMD_SPR_WR, 160, 255, 0, 0, 1'b0));
    directed.push_back(mk(CMD_SPR_WR, 8191, 255, 0, 0, 1'b0));
    directed.push_back(mk(CMD_SPR_WR, 159, 0, 0, 0, 1'b0));
    directed.push_back(mk(CMD_UNUSED, 8191, 255, 255, 255, 1'b0));
    directed.push_back(mk(CMD_RENDER, 0, 0, 77, 80, 1'b1));
    foreach (directed[i]) send_item(directed[i]);
    drain_pipeline();

    for (phase = 0; phase < 14; phase++) begin
      case (phase)
        0: set_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        1: set_regs(8'h93, 8'h00, 8'h00, 8'h00, 8'h07, 8'hE4);
        2: set_regs(8'hE7, 8'h10, 8'hF0, 8'h00, 8'h00, 8'h1B);
        3: set_regs(8'hA2, 8'h00, 8'h00, 8'h8F, 8'hA6, 8'hE4);
        4: set_regs(8'hFB, 8'h80, 8'h08, 8'h20, 8'hA7, 8'h6C);
        5: set_regs(8'h7F, 8'h33, 8'h44, 8'h00, 8'h50, 8'hFF);
        6: set_regs(8'h83, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        default: set_regs(8'($urandom_range(0, 255) | ($urandom_range(0, 5) ? 8'h80 : 8'h00)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 150)), 8'($urandom_range(0, 175)),
                          8'($urandom_range(0, 255)));
      endcase
      burst = $urandom_range(1, 40);
      for (int n = 0; n < 62; n++) begin
        r = random_item();
        send_item(r);
        if (--burst == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
          burst = $urandom_range(1, 40);
        end
      end
      drain_pipeline();
    end

    if (errors == 0 && pending_pixels.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
